/* design/mts_pkg.sv */
// ----------------------------------------------------------------------------
// Melody tone sequencer package
// Shared widths, codes and payload types of the melody tone sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

   // Fixed field widths.
   localparam int CMD_W     = 3;
   localparam int IDX_W     = 8;
   localparam int FREQ_W    = 14;
   localparam int MEAS_W    = 8;
   localparam int REP_W     = 7;
   localparam int MS_W      = 16;
   localparam int TEMPO_W   = 10;
   localparam int CLK_W     = 28;
   localparam int ENTRY_W   = FREQ_W + 1 + MEAS_W;

   // PWM divider format: 8 integer bits and DIV_FRAC_BITS fraction bits.
   localparam int DIV_FRAC_BITS = 4;
   localparam int DIV_W         = 8 + DIV_FRAC_BITS;

   // Default table depth.
   localparam int NOTE_SLOTS_DEFAULT = 256;

   // Iterative divider operand widths.
   localparam int DIVN_W = CLK_W + DIV_FRAC_BITS;
   localparam int DIVD_W = 28;

   // Constants of the timing and PWM arithmetic.
   localparam int WHOLE_NOTE_MS = 240000;
   localparam int PWM_WRAP      = 10000;
   localparam int DUR_W         = 18;

   // Configuration register indexes.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = CLK_W;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMPO    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REST     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK_HZ = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FREQ = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FREQ = 3'd4;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_START = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TONE  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_STOP  = 3'd4;

   // Datapath micro-operations issued by the controller.
   localparam int UOP_W = 4;
   localparam logic [UOP_W-1:0] UOP_NONE       = 4'd0;
   localparam logic [UOP_W-1:0] UOP_CAPTURE    = 4'd1;
   localparam logic [UOP_W-1:0] UOP_TICK       = 4'd2;
   localparam logic [UOP_W-1:0] UOP_LOAD       = 4'd3;
   localparam logic [UOP_W-1:0] UOP_START      = 4'd4;
   localparam logic [UOP_W-1:0] UOP_TONE       = 4'd5;
   localparam logic [UOP_W-1:0] UOP_STOP       = 4'd6;
   localparam logic [UOP_W-1:0] UOP_ENTRY      = 4'd7;
   localparam logic [UOP_W-1:0] UOP_MAG_START  = 4'd8;
   localparam logic [UOP_W-1:0] UOP_NOTE_SET   = 4'd9;
   localparam logic [UOP_W-1:0] UOP_FREQ_START = 4'd10;
   localparam logic [UOP_W-1:0] UOP_FREQ_SET   = 4'd11;
   localparam logic [UOP_W-1:0] UOP_RESPOND    = 4'd12;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic [IDX_W-1:0]         note_index;
      logic [FREQ_W-1:0]        note_freq;
      logic                     note_is_end;
      logic signed [MEAS_W-1:0] note_measure;
      logic [REP_W-1:0]         repeat_count;
      logic [MS_W-1:0]          tone_ms;
   } req_type;

   typedef struct packed {
      logic               pwm_enable;
      logic [DIV_W-1:0]   clock_divider;
      logic               playing;
      logic [IDX_W-1:0]   current_index;
      logic [REP_W-1:0]   repeats_remaining;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic [UOP_W-1:0] uop;
   } ctl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             tick_adv;
      logic             tone_go;
      logic             entry_end;
      logic             wrap_continue;
      logic             entry_has_freq;
      logic             freq_ok;
      logic             div_done;
      logic             rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

/* design/mts_divider.sv */
// ----------------------------------------------------------------------------
// Melody tone sequencer divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_divider #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 28
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  done,
   output logic [NUM_W-1:0]      quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   // One trial subtraction of the shifted remainder.
   assign trial = {rem_ff, quot_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = ~diff[DEN_W];

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[NUM_W-2:0], fits};
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is cleared by reset; operands need none.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

/* design/mts_datapath.sv */
// ----------------------------------------------------------------------------
// Melody tone sequencer datapath
// Note table, playback registers, configuration and the PWM divider maths.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_datapath import mts_pkg::*; #(
   parameter int NOTE_SLOTS = NOTE_SLOTS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire req_type               req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_payload,
   input  wire logic                  csr_valid,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire ctl_cmd_type           cmd,
   output dp_status_type              sts
);

   localparam int PTR_W = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_TONE = 2'd1;
   localparam logic [1:0] PH_NOTE = 2'd2;
   localparam logic [1:0] PH_REST = 2'd3;

   localparam logic [DIV_W-1:0] DIV_LO = DIV_W'(1 << DIV_FRAC_BITS);
   localparam logic [DIV_W-1:0] DIV_HI = {DIV_W{1'b1}};

   // Configuration registers.
   logic [TEMPO_W-1:0] tempo_ff;
   logic [MS_W-1:0]    rest_ff;
   logic [CLK_W-1:0]   clock_hz_ff;
   logic [FREQ_W-1:0]  min_freq_ff;
   logic [FREQ_W-1:0]  max_freq_ff;

   // Playback state.
   logic [1:0]       phase_ff, phase_in;
   logic [MS_W-1:0]  countdown_ff, countdown_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [REP_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] div_reg_ff, div_reg_in;
   logic             en_ff, en_in;

   // Working registers.
   req_type           req_ff;
   logic [FREQ_W-1:0] freq_ff, freq_in;
   logic [MEAS_W-1:0] mag_ff, mag_in;
   logic              dotted_ff, dotted_in;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   // Note table.
   logic [ENTRY_W-1:0] note_mem [NOTE_SLOTS];
   logic [ENTRY_W-1:0] rdata_ff;
   logic               mem_we;
   logic [PTR_W-1:0]   mem_waddr;

   // Divider interface.
   logic              div_start;
   logic [DIVN_W-1:0] div_numer;
   logic [DIVD_W-1:0] div_denom;
   logic              div_done;
   logic [DIVN_W-1:0] div_quot;

   // Decoded helpers.
   logic [TEMPO_W-1:0] tempo_eff;
   logic [FREQ_W-1:0]  ent_freq;
   logic               ent_end;
   logic [MEAS_W-1:0]  ent_meas;
   logic [MEAS_W-1:0]  mag_raw;
   logic [REP_W-1:0]   cnt_dec;
   logic [DUR_W-1:0]   dur_q;
   logic [DUR_W+1:0]   dur_x3;
   logic [DUR_W:0]     dur_full;
   logic [MS_W-1:0]    dur_sat;
   logic [DIVD_W-1:0]  freq_prod;
   logic               freq_ok;
   logic               tick_adv;
   logic [PTR_W-1:0]   ptr_next;
   logic               rsp_free;

   assign tempo_eff = (tempo_ff == '0) ? TEMPO_W'(1) : tempo_ff;
   assign ent_freq  = rdata_ff[FREQ_W-1:0];
   assign ent_end   = rdata_ff[FREQ_W];
   assign ent_meas  = rdata_ff[ENTRY_W-1:FREQ_W+1];
   assign mag_raw   = ent_meas[MEAS_W-1] ? (~ent_meas + 1'b1) : ent_meas;
   assign cnt_dec   = (cnt_ff != '0) ? cnt_ff - 1'b1 : cnt_ff;
   assign ptr_next  = (ptr_ff == PTR_W'(NOTE_SLOTS - 1)) ? '0 : ptr_ff + 1'b1;

   // Note duration: dotted notes take three halves, then saturate.
   assign dur_q    = div_quot[DUR_W-1:0];
   assign dur_x3   = {1'b0, dur_q, 1'b0} + (DUR_W + 2)'(dur_q);
   assign dur_full = dotted_ff ? dur_x3[DUR_W+1:1] : {1'b0, dur_q};
   assign dur_sat  = (dur_full > (DUR_W + 1)'({MS_W{1'b1}})) ? {MS_W{1'b1}}
                                                           : dur_full[MS_W-1:0];

   // Playable frequency check and the PWM period product.
   assign freq_ok   = (freq_ff != '0) && (freq_ff >= min_freq_ff) && (freq_ff <= max_freq_ff);
   assign freq_prod = DIVD_W'(freq_ff) * DIVD_W'(PWM_WRAP);

   // A tick that expires a note with no rest, or a rest, steps the melody.
   assign tick_adv = (phase_ff != PH_IDLE) && (countdown_ff <= MS_W'(1)) &&
                     ((phase_ff == PH_REST) ||
                      ((phase_ff == PH_NOTE) && (rest_ff == '0)));

   // Divider operand selection.
   always_comb begin
      div_start = 1'b0;
      div_numer = div_quot;
      div_denom = DIVD_W'(mag_ff);
      case (cmd.uop)
         UOP_ENTRY: begin
            div_start = ~ent_end;
            div_numer = DIVN_W'(WHOLE_NOTE_MS);
            div_denom = DIVD_W'(tempo_eff);
         end
         UOP_MAG_START: begin
            div_start = 1'b1;
         end
         UOP_FREQ_START: begin
            div_start = freq_ok;
            div_numer = {clock_hz_ff, {DIV_FRAC_BITS{1'b0}}};
            div_denom = freq_prod;
         end
         default: begin
         end
      endcase
   end

   mts_divider #(
      .NUM_W (DIVN_W),
      .DEN_W (DIVD_W)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Next state of the playback registers for each micro-operation.
   always_comb begin
      phase_in     = phase_ff;
      countdown_in = countdown_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      div_reg_in   = div_reg_ff;
      en_in        = en_ff;
      freq_in      = freq_ff;
      mag_in       = mag_ff;
      dotted_in    = dotted_ff;
      case (cmd.uop)
         UOP_TICK: begin
            if (phase_ff != PH_IDLE) begin
               if (countdown_ff > MS_W'(1)) begin
                  countdown_in = countdown_ff - 1'b1;
               end else begin
                  countdown_in = '0;
                  if (phase_ff == PH_TONE) begin
                     phase_in = PH_IDLE;
                     en_in    = 1'b0;
                  end else if (phase_ff == PH_NOTE) begin
                     en_in = 1'b0;
                     if (rest_ff != '0) begin
                        phase_in     = PH_REST;
                        countdown_in = rest_ff;
                     end
                  end
               end
            end
         end
         UOP_START: begin
            cnt_in = req_ff.repeat_count;
            ptr_in = '0;
         end
         UOP_TONE: begin
            if (req_ff.note_freq != '0) begin
               phase_in     = PH_TONE;
               countdown_in = req_ff.tone_ms;
               freq_in      = req_ff.note_freq;
            end
         end
         UOP_STOP: begin
            phase_in     = PH_IDLE;
            en_in        = 1'b0;
            countdown_in = '0;
            ptr_in       = '0;
            cnt_in       = '0;
         end
         UOP_ENTRY: begin
            if (ent_end) begin
               ptr_in = '0;
               cnt_in = cnt_dec;
               if (cnt_dec == '0) begin
                  phase_in     = PH_IDLE;
                  en_in        = 1'b0;
                  countdown_in = '0;
               end
            end else begin
               freq_in   = ent_freq;
               mag_in    = (mag_raw == '0) ? MEAS_W'(1) : mag_raw;
               dotted_in = ent_meas[MEAS_W-1];
            end
         end
         UOP_NOTE_SET: begin
            phase_in     = PH_NOTE;
            countdown_in = dur_sat;
            ptr_in       = ptr_next;
         end
         UOP_FREQ_START: begin
            if (!freq_ok) begin
               en_in = 1'b0;
            end
         end
         UOP_FREQ_SET: begin
            en_in = 1'b1;
            if (div_quot < DIVN_W'(DIV_LO)) begin
               div_reg_in = DIV_LO;
            end else if (div_quot > DIVN_W'(DIV_HI)) begin
               div_reg_in = DIV_HI;
            end else begin
               div_reg_in = div_quot[DIV_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // Result register: a new result may load as the old one leaves.
   assign rsp_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (cmd.uop == UOP_RESPOND) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         countdown_ff <= '0;
         ptr_ff       <= '0;
         cnt_ff       <= '0;
         div_reg_ff   <= DIV_LO;
         en_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         countdown_ff <= countdown_in;
         ptr_ff       <= ptr_in;
         cnt_ff       <= cnt_in;
         div_reg_ff   <= div_reg_in;
         en_ff        <= en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working payload registers.
   always_ff @(posedge clock) begin
      freq_ff   <= freq_in;
      mag_ff    <= mag_in;
      dotted_ff <= dotted_in;
      if (cmd.uop == UOP_CAPTURE) begin
         req_ff <= req_payload;
      end
      if (cmd.uop == UOP_RESPOND) begin
         rsp_ff.pwm_enable        <= en_ff;
         rsp_ff.clock_divider     <= div_reg_ff;
         rsp_ff.playing           <= (phase_ff != PH_IDLE);
         rsp_ff.current_index     <= IDX_W'(ptr_ff);
         rsp_ff.repeats_remaining <= cnt_ff;
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         tempo_ff    <= TEMPO_W'(120);
         rest_ff     <= MS_W'(10);
         clock_hz_ff <= CLK_W'(125000000);
         min_freq_ff <= FREQ_W'(49);
         max_freq_ff <= FREQ_W'(11840);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TEMPO:    tempo_ff    <= csr_data[TEMPO_W-1:0];
            CSR_REST:     rest_ff     <= csr_data[MS_W-1:0];
            CSR_CLOCK_HZ: clock_hz_ff <= csr_data[CLK_W-1:0];
            CSR_MIN_FREQ: min_freq_ff <= csr_data[FREQ_W-1:0];
            CSR_MAX_FREQ: max_freq_ff <= csr_data[FREQ_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Note table: one write port for loads, one registered read at the pointer.
   assign mem_we    = (cmd.uop == UOP_LOAD) && (32'(req_ff.note_index) < NOTE_SLOTS);
   assign mem_waddr = PTR_W'(req_ff.note_index);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         note_mem[mem_waddr] <= {req_ff.note_measure, req_ff.note_is_end, req_ff.note_freq};
      end
      rdata_ff <= note_mem[ptr_ff];
   end

   // Status towards the controller.
   assign sts.command        = req_ff.command;
   assign sts.tick_adv       = tick_adv;
   assign sts.tone_go        = (req_ff.note_freq != '0);
   assign sts.entry_end      = ent_end;
   assign sts.wrap_continue  = (cnt_dec != '0);
   assign sts.entry_has_freq = (ent_freq != '0);
   assign sts.freq_ok        = freq_ok;
   assign sts.div_done       = div_done;
   assign sts.rsp_free       = rsp_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

/* design/mts_controller.sv */
// ----------------------------------------------------------------------------
// Melody tone sequencer controller
// State machine that sequences one transaction through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_controller import mts_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type sts,
   output ctl_cmd_type        cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_READ     = 4'd2;
   localparam logic [3:0] S_EVAL     = 4'd3;
   localparam logic [3:0] S_DUR      = 4'd4;
   localparam logic [3:0] S_MAG      = 4'd5;
   localparam logic [3:0] S_FREQ     = 4'd6;
   localparam logic [3:0] S_FWAIT    = 4'd7;
   localparam logic [3:0] S_FINISH   = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.uop  = UOP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.uop  = UOP_CAPTURE;
               state_in = S_DISPATCH;
            end
         end
         // Decode the command and apply its immediate effect.
         S_DISPATCH: begin
            state_in = S_FINISH;
            case (sts.command)
               CMD_TICK: begin
                  cmd.uop = UOP_TICK;
                  if (sts.tick_adv) begin
                     state_in = S_READ;
                  end
               end
               CMD_LOAD: begin
                  cmd.uop = UOP_LOAD;
               end
               CMD_START: begin
                  cmd.uop  = UOP_START;
                  state_in = S_READ;
               end
               CMD_TONE: begin
                  cmd.uop = UOP_TONE;
                  if (sts.tone_go) begin
                     state_in = S_FREQ;
                  end
               end
               CMD_STOP: begin
                  cmd.uop = UOP_STOP;
               end
               default: begin
               end
            endcase
         end
         // Table read data is registered, so wait here for it.
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.uop = UOP_ENTRY;
            if (sts.entry_end) begin
               state_in = sts.wrap_continue ? S_READ : S_FINISH;
            end else begin
               state_in = S_DUR;
            end
         end
         S_DUR: begin
            if (sts.div_done) begin
               cmd.uop  = UOP_MAG_START;
               state_in = S_MAG;
            end
         end
         S_MAG: begin
            if (sts.div_done) begin
               cmd.uop  = UOP_NOTE_SET;
               state_in = sts.entry_has_freq ? S_FREQ : S_FINISH;
            end
         end
         S_FREQ: begin
            cmd.uop  = UOP_FREQ_START;
            state_in = sts.freq_ok ? S_FWAIT : S_FINISH;
         end
         S_FWAIT: begin
            if (sts.div_done) begin
               cmd.uop  = UOP_FREQ_SET;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               cmd.uop  = UOP_RESPOND;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

`default_nettype wire

/* design/melody_tone_sequencer.sv */
// ----------------------------------------------------------------------------
// Melody tone sequencer
// Buzzer tone and melody player driven by one-millisecond tick transactions.
// ----------------------------------------------------------------------------
// Each request transaction gives exactly one response transaction carrying the
// state after the command. A command that starts a sounding note runs two
// duration divisions and one PWM division on the single bit-serial divider,
// plus decode, table read and hand-off. A rest note skips the PWM division, a
// single tone needs only the PWM division, and a melody that finishes at its
// end entry needs none; each end-of-table entry that wraps adds another table
// read. One request is worked on at a time, while a finished response may
// still wait in the output register. Configuration writes are taken at any
// cycle but belong in idle periods.
`default_nettype none

module melody_tone_sequencer import mts_pkg::*; #(
   parameter int NOTE_SLOTS = NOTE_SLOTS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_payload,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   ctl_cmd_type   cmd;
   dp_status_type sts;

   // Registers accept a write in any cycle.
   assign csr_ready = 1'b1;

   mts_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mts_datapath #(
      .NOTE_SLOTS (NOTE_SLOTS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

`default_nettype wire

/* design/mts_checker.sv */
// ----------------------------------------------------------------------------
// Melody tone sequencer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_checker import mts_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire rsp_type               rsp_payload
);

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // One transaction is worked on at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // The tone output is only driven while something plays.
   a_enable_playing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_payload.pwm_enable || rsp_payload.playing)
      else $error("tone driven while idle");

   // The divider never drops below one.
   a_divider_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.clock_divider >= DIV_W'(1 << DIV_FRAC_BITS))
      else $error("divider below its minimum");

   // No response straight after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response after reset");

endmodule

bind melody_tone_sequencer mts_checker u_checker (.*);

`default_nettype wire

/* test/tone_sequence_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Melody tone sequencer checker
// Watches the request, response and register write channels of the melody
// tone sequencer. It keeps its own copy of the note table, the play state and
// the register settings, works out the status that each request leads to, and
// compares every response field by field with the oldest outstanding status.
// ----------------------------------------------------------------------------
`default_nettype none

module tone_sequence_checker import mts_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire req_type               req_payload,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire rsp_type               rsp_payload,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output int                         fail_count,
   output int                         pending
);

   typedef enum logic [1:0] {
      PLAY_IDLE,
      PLAY_TONE,
      PLAY_NOTE,
      PLAY_REST
   } play_phase_type;

   typedef struct packed {
      logic signed [MEAS_W-1:0] measure;
      logic                     is_end;
      logic [FREQ_W-1:0]        freq;
   } note_entry_type;

   // Mirror of the block's table, play state and registers.
   note_entry_type   notes [NOTE_SLOTS_DEFAULT];
   play_phase_type   play_phase;
   logic [MS_W-1:0]  remaining_ms;
   logic [IDX_W-1:0] next_slot;
   logic [REP_W-1:0] plays_left;
   logic [DIV_W-1:0] pwm_divider;
   logic             pwm_on;
   logic [TEMPO_W-1:0] tempo;
   logic [MS_W-1:0]    gap_ms;
   logic [CLK_W-1:0]   sys_clock_hz;
   logic [FREQ_W-1:0]  lowest_freq;
   logic [FREQ_W-1:0]  highest_freq;

   rsp_type expected_status [$];

   // Sets up the PWM for a frequency, or silences it when out of range.
   function automatic void tune_pwm(input logic [FREQ_W-1:0] freq);
      longint unsigned num;
      longint unsigned den;
      longint unsigned q;
      if (freq == 0 || freq < lowest_freq || freq > highest_freq) begin
         pwm_on = 1'b0;
         return;
      end
      num = longint'(sys_clock_hz) << DIV_FRAC_BITS;
      den = longint'(freq) * PWM_WRAP;
      q = num / den;
      if (q < (1 << DIV_FRAC_BITS)) q = 1 << DIV_FRAC_BITS;
      if (q > (1 << DIV_W) - 1) q = (1 << DIV_W) - 1;
      pwm_divider = q[DIV_W-1:0];
      pwm_on = 1'b1;
   endfunction

   function automatic void fall_silent();
      play_phase = PLAY_IDLE;
      pwm_on = 1'b0;
      remaining_ms = '0;
   endfunction

   // Steps through the table until a note starts or the melody finishes.
   function automatic void next_note();
      note_entry_type e;
      int unsigned mag;
      int unsigned beats;
      int unsigned dur;
      forever begin
         e = notes[next_slot];
         if (e.is_end) begin
            next_slot = '0;
            if (plays_left > 0) plays_left = plays_left - 1'b1;
            if (plays_left == 0) begin
               fall_silent();
               return;
            end
         end else begin
            mag = e.measure[MEAS_W-1] ? 256 - int'(unsigned'(e.measure))
                                      : int'(unsigned'(e.measure));
            if (mag == 0) mag = 1;
            beats = (tempo == 0) ? 1 : tempo;
            dur = (WHOLE_NOTE_MS / beats) / mag;
            if (e.measure[MEAS_W-1]) dur = dur * 3 / 2;
            if (dur > 65535) dur = 65535;
            if (e.freq != 0) tune_pwm(e.freq);
            play_phase = PLAY_NOTE;
            remaining_ms = dur[MS_W-1:0];
            next_slot = next_slot + 1'b1;
            return;
         end
      end
   endfunction

   function automatic void count_millisecond();
      if (play_phase == PLAY_IDLE) return;
      if (remaining_ms > 1) begin
         remaining_ms = remaining_ms - 1'b1;
         return;
      end
      remaining_ms = '0;
      case (play_phase)
         PLAY_TONE: begin
            fall_silent();
         end
         PLAY_NOTE: begin
            pwm_on = 1'b0;
            if (gap_ms > 0) begin
               play_phase = PLAY_REST;
               remaining_ms = gap_ms;
            end else begin
               next_note();
            end
         end
         default: begin
            next_note();
         end
      endcase
   endfunction

   // Applies one command and returns the status that the block must report.
   function automatic rsp_type predict_status(input req_type r);
      rsp_type s;
      case (r.command)
         CMD_TICK: begin
            count_millisecond();
         end
         CMD_LOAD: begin
            notes[r.note_index] = '{r.note_measure, r.note_is_end, r.note_freq};
         end
         CMD_START: begin
            plays_left = r.repeat_count;
            next_slot = '0;
            next_note();
         end
         CMD_TONE: begin
            if (r.note_freq != 0) begin
               tune_pwm(r.note_freq);
               play_phase = PLAY_TONE;
               remaining_ms = r.tone_ms;
            end
         end
         CMD_STOP: begin
            fall_silent();
            next_slot = '0;
            plays_left = '0;
         end
         default: begin
         end
      endcase
      s.pwm_enable = pwm_on;
      s.clock_divider = pwm_divider;
      s.playing = (play_phase != PLAY_IDLE);
      s.current_index = next_slot;
      s.repeats_remaining = plays_left;
      return s;
   endfunction

   // Watch the three channels at each edge.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (notes[i]) notes[i] = '0;
         play_phase = PLAY_IDLE;
         remaining_ms = '0;
         next_slot = '0;
         plays_left = '0;
         pwm_divider = DIV_W'(16);
         pwm_on = 1'b0;
         tempo = TEMPO_W'(120);
         gap_ms = MS_W'(10);
         sys_clock_hz = CLK_W'(125000000);
         lowest_freq = FREQ_W'(49);
         highest_freq = FREQ_W'(11840);
         expected_status.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: response transaction with no request outstanding: %p",
                           $time, rsp_payload);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_status.pop_front();
               if (want.pwm_enable !== rsp_payload.pwm_enable
                   || want.clock_divider !== rsp_payload.clock_divider
                   || want.playing !== rsp_payload.playing
                   || want.current_index !== rsp_payload.current_index
                   || want.repeats_remaining !== rsp_payload.repeats_remaining) begin
                  if (fail_count < 10)
                     $display("%0t: status mismatch: expected %p, got %p",
                              $time, want, rsp_payload);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TEMPO:    tempo = csr_data[TEMPO_W-1:0];
               CSR_REST:     gap_ms = csr_data[MS_W-1:0];
               CSR_CLOCK_HZ: sys_clock_hz = csr_data[CLK_W-1:0];
               CSR_MIN_FREQ: lowest_freq = csr_data[FREQ_W-1:0];
               CSR_MAX_FREQ: highest_freq = csr_data[FREQ_W-1:0];
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready)
            expected_status.push_back(predict_status(req_payload));
      end
      pending <= expected_status.size();
   end

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Melody tone sequencer testbench
// Drives tick, load, start, tone, stop and unused commands into the sequencer over
// several register settings and idle patterns, while a checker beside the
// block predicts and compares every status response.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import mts_pkg::*; ();

   localparam int RANDOM_PER_SETTING = 420;
   localparam int CYCLE_LIMIT = 3000000;

   // Command codes that the block does not use.
   localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int                    fail_count;
   int                    pending;
   int                    cycle_count = 0;
   int                    send_idle_pct = 0;
   int                    take_idle_pct = 0;

   // Which table slots hold a note and which hold an end marker.
   bit slot_loaded [NOTE_SLOTS_DEFAULT];
   bit slot_is_end [NOTE_SLOTS_DEFAULT];

   melody_tone_sequencer uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   tone_sequence_checker u_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   always #1 clock = ~clock;

   // The receiver stalls at random.
   always @(posedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= take_idle_pct);

   // Guard against a hung block.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic req_type command_item(input logic [CMD_W-1:0] cmd,
                                            input int idx, input int freq,
                                            input bit is_end, input int meas,
                                            input int rep, input int ms);
      req_type r;
      r.command = cmd;
      r.note_index = idx[IDX_W-1:0];
      r.note_freq = freq[FREQ_W-1:0];
      r.note_is_end = is_end;
      r.note_measure = meas[MEAS_W-1:0];
      r.repeat_count = rep[REP_W-1:0];
      r.tone_ms = ms[MS_W-1:0];
      return r;
   endfunction

   // Sends one request transaction, with a gap of random length, or none, before it.
   task automatic send_command(input req_type r);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      if (r.command == CMD_LOAD) begin
         slot_loaded[r.note_index] = 1'b1;
         slot_is_end[r.note_index] = r.note_is_end;
      end
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CSR_DATA_W-1:0];
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
   endtask

   // Waits until every status has come back, with the request line quiet.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Writes all five registers back to back, then releases the write channel.
   task automatic apply_setting(input int tempo_v, input int rest_v, input int clk_v,
                                input int lo_v, input int hi_v);
      write_register(CSR_TEMPO, tempo_v);
      write_register(CSR_REST, rest_v);
      write_register(CSR_CLOCK_HZ, clk_v);
      write_register(CSR_MIN_FREQ, lo_v);
      write_register(CSR_MAX_FREQ, hi_v);
      csr_valid <= 1'b0;
   endtask

   function automatic int pick_freq();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return 0;
      if (roll < 25) return $urandom_range(0, 16383);
      return $urandom_range(100, 4000);
   endfunction

   // A random command that never lets a melody run into an empty slot.
   function automatic req_type random_command();
      req_type r;
      int roll;
      int idx;
      int meas;
      int freq;
      int rep;
      int ms;
      bit is_end;
      r = command_item(CMD_TICK, $urandom_range(0, 255), $urandom_range(0, 16383),
                       $urandom_range(0, 1), $urandom_range(0, 255),
                       $urandom_range(0, 127), $urandom_range(0, 65535));
      roll = $urandom_range(0, 99);
      if (roll < 58) begin
         r.command = CMD_TICK;
      end else if (roll < 78) begin
         r.command = CMD_LOAD;
         idx = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 15) : $urandom_range(0, 255);
         meas = $urandom_range(8, 64);
         if ($urandom_range(0, 1)) meas = -meas;
         if ($urandom_range(0, 19) == 0) meas = $urandom_range(0, 255);
         is_end = ($urandom_range(0, 99) < 15);
         // A note must always be followed by a loaded slot.
         if (!slot_loaded[(idx + 1) % NOTE_SLOTS_DEFAULT]) is_end = 1'b1;
         freq = pick_freq();
         r.note_index = idx[IDX_W-1:0];
         r.note_freq = freq[FREQ_W-1:0];
         r.note_is_end = is_end;
         r.note_measure = meas[MEAS_W-1:0];
      end else if (roll < 86) begin
         r.command = slot_loaded[0] ? CMD_START : CMD_TICK;
         rep = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(0, 127);
         r.repeat_count = rep[REP_W-1:0];
      end else if (roll < 94) begin
         r.command = CMD_TONE;
         freq = pick_freq();
         r.note_freq = freq[FREQ_W-1:0];
         ms = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 20);
         r.tone_ms = ms[MS_W-1:0];
      end else if (roll < 97) begin
         r.command = CMD_STOP;
      end else begin
         r.command = CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
      end
      return r;
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed commands with fast tempo and the full frequency range.
      apply_setting(1000, 2, 200000000, 1, 16383);
      send_command(command_item(CMD_TICK, 0, 0, 0, 0, 0, 0));
      send_command(command_item(CMD_UNUSED_FIRST, 255, 16383, 1, -1, 127, 65535));
      send_command(command_item(CMD_UNUSED_LAST, 0, 0, 0, 0, 0, 0));
      // Table filled from the end so that no note ever points at an empty slot.
      send_command(command_item(CMD_LOAD, 4, 0, 1, 0, 0, 0));
      send_command(command_item(CMD_LOAD, 3, 16383, 0, -128, 0, 0));
      send_command(command_item(CMD_LOAD, 2, 1, 0, 0, 0, 0));
      send_command(command_item(CMD_LOAD, 1, 0, 0, -64, 0, 0));
      send_command(command_item(CMD_LOAD, 0, 440, 0, 64, 0, 0));
      send_command(command_item(CMD_LOAD, 255, 0, 1, 127, 0, 0));
      send_command(command_item(CMD_START, 0, 0, 0, 0, 2, 0));
      repeat (5) send_command(command_item(CMD_TICK, 0, 0, 0, 0, 0, 0));
      send_command(command_item(CMD_TONE, 0, 1000, 0, 0, 0, 0));
      send_command(command_item(CMD_TICK, 0, 0, 0, 0, 0, 0));
      send_command(command_item(CMD_TONE, 0, 0, 0, 0, 0, 5));
      send_command(command_item(CMD_TONE, 0, 16383, 0, 0, 0, 65535));
      send_command(command_item(CMD_STOP, 0, 0, 0, 0, 0, 0));
      send_command(command_item(CMD_START, 0, 0, 0, 0, 0, 0));
      send_command(command_item(CMD_STOP, 0, 0, 0, 0, 0, 0));
      send_command(command_item(CMD_START, 0, 0, 0, 0, 127, 0));
      send_command(command_item(CMD_STOP, 0, 0, 0, 0, 0, 0));
      drain();

      // Random commands under four register settings and three idle patterns.
      for (int setting = 0; setting < 4; setting++) begin
         case (setting)
            0: apply_setting(1000, 0, 200000000, 1, 16383);
            1: apply_setting(1, 65535, 1000000, 16383, 1);
            2: apply_setting(0, 1, 125000000, 49, 11840);
            default: apply_setting($urandom_range(200, 1000), $urandom_range(0, 3),
                                   $urandom_range(1000000, 200000000),
                                   $urandom_range(20, 300), $urandom_range(2000, 16383));
         endcase
         send_idle_pct = (setting < 2) ? 16 : (setting == 2) ? 54 : 0;
         take_idle_pct = (setting < 2) ? 54 : (setting == 2) ? 16 : 0;
         repeat (RANDOM_PER_SETTING) send_command(random_command());
         drain();
      end

      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
design/mts_pkg.sv
design/mts_divider.sv
design/mts_datapath.sv
design/mts_controller.sv
design/melody_tone_sequencer.sv
design/mts_checker.sv
test/tone_sequence_checker.sv
test/testbench.sv
